// File: sv/q4_q8_block_dot_accumulator_unit_defines.svh
// ----------------------------------------------------------------------------
// q4_q8_block_dot_accumulator_unit_defines
// Assertion macros used by the checker file of the dot accumulator.
// ----------------------------------------------------------------------------
`ifndef Q4_Q8_BLOCK_DOT_ACCUMULATOR_UNIT_DEFINES_SVH
`define Q4_Q8_BLOCK_DOT_ACCUMULATOR_UNIT_DEFINES_SVH

// same-cycle implication, disabled while rst_n is low
`define Q4Q8_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("q4q8 same-cycle check failed");

// next-cycle implication, disabled while rst_n is low
`define Q4Q8_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("q4q8 next-cycle check failed");

`endif

// File: sv/q4q8_pkg.sv
// ----------------------------------------------------------------------------
// q4q8_pkg
// Shared types and constants of the q4/q8 block dot accumulator.
// ----------------------------------------------------------------------------
package q4q8_pkg;

    // block integer sum width
    localparam int SUM_W = 20;
    // product of block integer and 24-bit scale mantissa
    localparam int PROD_W = SUM_W + 24;
    // working window of the normalize / round datapath
    localparam int FP_W = 96;
    // signed exponent width inside the float datapath
    localparam int EXP_W = 11;

    localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [3:0]  NIB_FLIP  = 4'h8;

    // one request from the front to the back
    typedef struct packed {
        logic [SUM_W-1:0] block_value;
        logic [15:0]      weight_scale_half;
        logic [31:0]      activation_scale_bits;
        logic             do_block;
        logic             do_row;
    } q4q8_op_t;

    // back-end sequencer
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCALE_MUL,
        ST_FMA_MUL,
        ST_FMA_ALIGN,
        ST_FMA_SUM,
        ST_NORM,
        ST_ROUND,
        ST_EMIT
    } q4q8_state_t;

endpackage

// File: sv/q4q8_fifo.sv
// ----------------------------------------------------------------------------
// q4q8_fifo
// Short request queue between the front and the back.
// ----------------------------------------------------------------------------
module q4q8_fifo #(
    parameter int DEPTH = 2
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  q4q8_pkg::q4q8_op_t wr_data,
    output logic               rd_valid,
    input  logic               rd_ready,
    output q4q8_pkg::q4q8_op_t rd_data
);
    import q4q8_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    q4q8_op_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign wr_ready = (count_reg != CNT_W'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // pointer and count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + 1'b1;
        end else if (!do_wr && do_rd) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: sv/q4q8_front.sv
// ----------------------------------------------------------------------------
// q4q8_front
// Accepts chunks, adds lane products into the block integer sum and queues
// block-close and row-end requests for the float back end.
// ----------------------------------------------------------------------------
module q4q8_front #(
    parameter int LANES = 8,
    parameter int TDATA_W = 160
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [TDATA_W-1:0] s_tdata,
    input  logic               s_tuser,
    input  logic               s_tlast,
    output logic               op_valid,
    input  logic               op_ready,
    output q4q8_pkg::q4q8_op_t op_data
);
    import q4q8_pkg::*;

    localparam int NW = 4 * LANES;
    localparam int NA = 8 * LANES;
    localparam int SUM_OFS = NW + NA;
    localparam int WS_OFS = SUM_OFS + 13;
    localparam int AS_OFS = WS_OFS + 16;

    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic signed [SUM_W-1:0] chunk_sum;
    logic [SUM_W-1:0]        closed_sum;
    logic [SUM_W-1:0]        act_sum_x8;
    logic                    accept;
    logic signed [12:0]      lane_prod;

    assign s_tready = op_ready;
    assign accept   = s_tvalid && s_tready;

    // lane products: (nibble ^ 8) unsigned times signed activation
    always_comb begin
        chunk_sum = '0;
        lane_prod = '0;
        for (int j = 0; j < LANES; j++) begin
            lane_prod = $signed({1'b0, s_tdata[4*j +: 4] ^ NIB_FLIP})
                        * $signed(s_tdata[NW + 8*j +: 8]);
            chunk_sum = chunk_sum + SUM_W'(lane_prod);
        end
    end

    // block close value: running sum minus 8 x activation sum, 20-bit wrap
    assign closed_sum = sum_reg + chunk_sum;
    assign act_sum_x8 = SUM_W'($signed(s_tdata[SUM_OFS +: 13])) << 3;

    always_comb begin
        op_data.block_value           = closed_sum - act_sum_x8;
        op_data.weight_scale_half     = s_tdata[WS_OFS +: 16];
        op_data.activation_scale_bits = s_tdata[AS_OFS +: 32];
        op_data.do_block              = s_tuser;
        op_data.do_row                = s_tlast;
        op_valid                      = accept && (s_tuser || s_tlast);
    end

    always_comb begin
        sum_next = sum_reg;
        if (accept) begin
            sum_next = s_tuser ? '0 : closed_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
        end else begin
            sum_reg <= sum_next;
        end
    end

endmodule

// File: sv/q4q8_back.sv
// ----------------------------------------------------------------------------
// q4q8_back
// Float back end: scale product, fused multiply-add into the fp32 total,
// shared normalize / round loop, and the result output register.
// ----------------------------------------------------------------------------
module q4q8_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               op_valid,
    output logic               op_ready,
    input  q4q8_pkg::q4q8_op_t op_data,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [31:0]        m_tdata
);
    import q4q8_pkg::*;

    function automatic logic f32_nan(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] != 23'd0);
    endfunction

    function automatic logic f32_inf(input logic [31:0] x);
        return (x[30:23] == 8'hFF) && (x[22:0] == 23'd0);
    endfunction

    function automatic logic [23:0] f32_mant(input logic [31:0] x);
        return {x[30:23] != 8'd0, x[22:0]};
    endfunction

    // exponent of the mantissa LSB
    function automatic logic signed [EXP_W-1:0] f32_exp(input logic [31:0] x);
        logic signed [EXP_W-1:0] e;
        e = (x[30:23] == 8'd0) ? EXP_W'(-149) : $signed(EXP_W'(x[30:23])) - EXP_W'(150);
        return e;
    endfunction

    q4q8_state_t             state_reg, state_next;
    q4q8_op_t                op_reg, op_next;
    logic                    fma_phase_reg, fma_phase_next;
    logic [31:0]             total_reg, total_next;
    logic [31:0]             scale_reg, scale_next;
    logic [FP_W-1:0]         win_reg, win_next;
    logic signed [EXP_W-1:0] bexp_reg, bexp_next;
    logic                    sign_reg, sign_next;
    logic [PROD_W-1:0]       prod_reg, prod_next;
    logic signed [EXP_W-1:0] pexp_reg, pexp_next;
    logic                    psign_reg, psign_next;
    logic [FP_W-1:0]         a_reg, a_next;
    logic [FP_W-1:0]         b_reg, b_next;
    logic                    sub_reg, sub_next;
    logic signed [EXP_W-1:0] tbig_reg, tbig_next;
    logic                    out_valid_reg, out_valid_next;
    logic [31:0]             out_data_reg, out_data_next;

    // scale operands
    logic [15:0]             hw;
    logic [31:0]             aw;
    logic                    h_nan, h_inf, h_zero, a_nan, a_inf, a_zero;
    logic [10:0]             h_mant;
    logic signed [EXP_W-1:0] h_exp;
    logic [34:0]             scale_mul;
    logic                    scale_special;
    logic [31:0]             scale_special_bits;

    // fma operands
    logic                    iv_neg, iv_zero;
    logic [SUM_W-1:0]        iv_mag;
    logic [PROD_W-1:0]       fma_mul;
    logic                    fma_special;
    logic [31:0]             fma_special_bits;
    logic                    prod_sign;

    // alignment
    logic                    p_zero, c_zero, p_big;
    logic signed [EXP_W-1:0] tp, tc, tdiff;
    logic [FP_W-1:0]         xp, xc, xs, xshift, xlost;
    logic [EXP_W-1:0]        dsh;

    // add
    logic [FP_W:0]           sum_ext, sum_mag;

    // normalize / round
    logic                    shift8, shift1, norm_done;
    logic                    rnd_inc, rnd_ovf;
    logic [30:0]             rnd_mag;
    logic [31:0]             rnd_bits;
    logic                    emit_ok;

    // ------------------------------------------------------------------
    // scale product operands
    assign hw     = op_reg.weight_scale_half;
    assign aw     = op_reg.activation_scale_bits;
    assign h_nan  = (hw[14:10] == 5'h1F) && (hw[9:0] != 10'd0);
    assign h_inf  = (hw[14:10] == 5'h1F) && (hw[9:0] == 10'd0);
    assign h_zero = (hw[14:0] == 15'd0);
    assign a_nan  = f32_nan(aw);
    assign a_inf  = f32_inf(aw);
    assign a_zero = (aw[30:0] == 31'd0);
    assign h_mant = {hw[14:10] != 5'd0, hw[9:0]};
    assign h_exp  = (hw[14:10] == 5'd0) ? EXP_W'(-24)
                                        : $signed(EXP_W'(hw[14:10])) - EXP_W'(25);
    assign scale_mul     = h_mant * f32_mant(aw);
    assign scale_special = h_nan || h_inf || a_nan || a_inf;
    assign scale_special_bits =
        (h_nan || a_nan || (h_inf && a_zero) || (a_inf && h_zero)) ? CANON_NAN
                                                      : {hw[15] ^ aw[31], 8'hFF, 23'd0};

    // ------------------------------------------------------------------
    // block integer times scale
    assign iv_neg    = op_reg.block_value[SUM_W-1];
    assign iv_zero   = (op_reg.block_value == '0);
    assign iv_mag    = iv_neg ? (~op_reg.block_value + 1'b1) : op_reg.block_value;
    assign fma_mul   = iv_mag * f32_mant(scale_reg);
    assign prod_sign = iv_neg ^ scale_reg[31];
    assign fma_special = f32_nan(scale_reg) || f32_nan(total_reg)
                         || f32_inf(scale_reg) || f32_inf(total_reg);

    always_comb begin
        if (f32_nan(scale_reg) || f32_nan(total_reg)) begin
            fma_special_bits = CANON_NAN;
        end else if (f32_inf(scale_reg)) begin
            if (iv_zero || (f32_inf(total_reg) && (total_reg[31] != prod_sign))) begin
                fma_special_bits = CANON_NAN;
            end else begin
                fma_special_bits = {prod_sign, 8'hFF, 23'd0};
            end
        end else begin
            fma_special_bits = total_reg;
        end
    end

    // ------------------------------------------------------------------
    // alignment of product and total into the window
    assign p_zero = (prod_reg == '0);
    assign c_zero = (total_reg[30:0] == 31'd0);
    assign tp     = pexp_reg + EXP_W'(PROD_W);
    assign tc     = f32_exp(total_reg) + EXP_W'(24);
    assign p_big  = c_zero || (tp >= tc);
    assign xp     = FP_W'(prod_reg) << (FP_W - 2 - PROD_W);
    assign xc     = c_zero ? '0 : (FP_W'(f32_mant(total_reg)) << (FP_W - 2 - 24));
    assign xs     = p_big ? xc : xp;
    assign tdiff  = p_big ? (tp - tc) : (tc - tp);
    assign dsh    = c_zero ? '0 : EXP_W'(tdiff);
    assign xshift = xs >> dsh;
    assign xlost  = xs & ~({FP_W{1'b1}} << dsh);

    // ------------------------------------------------------------------
    // signed magnitude add
    assign sum_ext = sub_reg ? ({1'b0, a_reg} - {1'b0, b_reg})
                             : ({1'b0, a_reg} + {1'b0, b_reg});
    assign sum_mag = sum_ext[FP_W] ? (~sum_ext + 1'b1) : sum_ext;

    // ------------------------------------------------------------------
    // normalize step and rounding
    assign shift8    = (win_reg[FP_W-1 -: 8] == 8'd0) && (bexp_reg > EXP_W'(8));
    assign shift1    = !win_reg[FP_W-1] && (bexp_reg > EXP_W'(1));
    assign norm_done = !shift8 && !shift1;
    assign rnd_inc   = win_reg[FP_W-25] && ((|win_reg[FP_W-26:0]) || win_reg[FP_W-24]);
    assign rnd_ovf   = win_reg[FP_W-1] && (bexp_reg >= EXP_W'(255));
    assign rnd_mag   = {(win_reg[FP_W-1] ? bexp_reg[7:0] : 8'd0), win_reg[FP_W-2 -: 23]}
                       + 31'(rnd_inc);
    assign rnd_bits  = rnd_ovf ? {sign_reg, 8'hFF, 23'd0} : {sign_reg, rnd_mag};

    assign emit_ok = !out_valid_reg || m_tready;

    // ------------------------------------------------------------------
    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (op_valid) begin
                    state_next = op_data.do_block ? ST_SCALE_MUL : ST_EMIT;
                end
            end
            ST_SCALE_MUL: state_next = scale_special ? ST_FMA_MUL : ST_NORM;
            ST_NORM:      state_next = norm_done ? ST_ROUND : ST_NORM;
            ST_ROUND: begin
                if (!fma_phase_reg) begin
                    state_next = ST_FMA_MUL;
                end else begin
                    state_next = op_reg.do_row ? ST_EMIT : ST_IDLE;
                end
            end
            ST_FMA_MUL: begin
                if (fma_special) begin
                    state_next = op_reg.do_row ? ST_EMIT : ST_IDLE;
                end else begin
                    state_next = ST_FMA_ALIGN;
                end
            end
            ST_FMA_ALIGN: begin
                if (p_zero) begin
                    state_next = op_reg.do_row ? ST_EMIT : ST_IDLE;
                end else begin
                    state_next = ST_FMA_SUM;
                end
            end
            ST_FMA_SUM:   state_next = ST_NORM;
            ST_EMIT:      state_next = emit_ok ? ST_IDLE : ST_EMIT;
            default:      state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // datapath and outputs
    always_comb begin
        op_ready       = (state_reg == ST_IDLE);
        op_next        = op_reg;
        fma_phase_next = fma_phase_reg;
        total_next     = total_reg;
        scale_next     = scale_reg;
        win_next       = win_reg;
        bexp_next      = bexp_reg;
        sign_next      = sign_reg;
        prod_next      = prod_reg;
        pexp_next      = pexp_reg;
        psign_next     = psign_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        sub_next       = sub_reg;
        tbig_next      = tbig_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        case (state_reg)
            ST_IDLE: begin
                if (op_valid) begin
                    op_next = op_data;
                end
            end
            ST_SCALE_MUL: begin
                fma_phase_next = 1'b0;
                scale_next     = scale_special_bits;
                win_next       = FP_W'(scale_mul);
                bexp_next      = h_exp + f32_exp(aw) + EXP_W'(FP_W - 1 + 127);
                sign_next      = hw[15] ^ aw[31];
            end
            ST_NORM: begin
                if (shift8) begin
                    win_next  = win_reg << 8;
                    bexp_next = bexp_reg - EXP_W'(8);
                end else if (shift1) begin
                    win_next  = win_reg << 1;
                    bexp_next = bexp_reg - EXP_W'(1);
                end
            end
            ST_ROUND: begin
                if (fma_phase_reg) begin
                    total_next = rnd_bits;
                end else begin
                    scale_next = rnd_bits;
                end
            end
            ST_FMA_MUL: begin
                fma_phase_next = 1'b1;
                prod_next      = fma_mul;
                pexp_next      = f32_exp(scale_reg);
                psign_next     = prod_sign;
                if (fma_special) begin
                    total_next = fma_special_bits;
                end
            end
            ST_FMA_ALIGN: begin
                a_next    = p_big ? xp : xc;
                b_next    = xshift | FP_W'(|xlost);
                sub_next  = psign_reg ^ total_reg[31];
                sign_next = p_big ? psign_reg : total_reg[31];
                tbig_next = p_big ? tp : tc;
                if (p_zero && c_zero) begin
                    total_next = {psign_reg && total_reg[31], 31'd0};
                end
            end
            ST_FMA_SUM: begin
                win_next  = sum_mag[FP_W-1:0];
                bexp_next = tbig_reg + EXP_W'(128);
                sign_next = (sum_mag == '0) ? 1'b0 : (sign_reg ^ sum_ext[FP_W]);
            end
            ST_EMIT: begin
                if (emit_ok) begin
                    out_valid_next = 1'b1;
                    out_data_next  = total_reg;
                    total_next     = 32'd0;
                end
            end
            default: begin
                op_ready = 1'b0;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            total_reg     <= 32'd0;
            out_valid_reg <= 1'b0;
            fma_phase_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
            fma_phase_reg <= fma_phase_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        op_reg       <= op_next;
        scale_reg    <= scale_next;
        win_reg      <= win_next;
        bexp_reg     <= bexp_next;
        sign_reg     <= sign_next;
        prod_reg     <= prod_next;
        pexp_reg     <= pexp_next;
        psign_reg    <= psign_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        sub_reg      <= sub_next;
        tbig_reg     <= tbig_next;
        out_data_reg <= out_data_next;
    end

endmodule

// File: sv/q4_q8_block_dot_accumulator_unit.sv
// Path: a plain chunk is added into the registered block sum; with the back end idle a row end
//   alone passes the request queue, the back-end op register and the result output register.
// Throughput: one chunk per cycle while the request queue has room; a block close holds
//   the back end for the scale and fused multiplies, and for ordinary values also for align,
//   sum and normalize / round, longest when it normalizes a zero or deeply cancelled sum.
// Reset: synchronous, active low; clears block sum, fp32 total, queue, sequencer, out valid.
// ----------------------------------------------------------------------------
// q4_q8_block_dot_accumulator_unit
// Block-scaled q4 x q8 dot product with fp32 fused accumulation per row.
// ----------------------------------------------------------------------------
module q4_q8_block_dot_accumulator_unit #(
    parameter int LANES = 8,
    parameter int QUEUE_DEPTH = 2,
    localparam int S_TDATA_W = ((12 * LANES + 61 + 7) / 8) * 8
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // weight_nibbles, activation_bytes, activation_sum, weight_scale_half,
    // activation_scale_bits (lowest first), zero padded
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic                 s_tuser,   // block_end
    input  logic                 s_tlast,   // row_end
    input  logic                 s_tvalid,
    output logic                 s_tready,
    output logic [31:0]          m_tdata,   // dot_result_bits
    output logic                 m_tvalid,
    input  logic                 m_tready
);
    import q4q8_pkg::*;

    q4q8_op_t push_data, pop_data;
    logic     push_valid, push_ready, pop_valid, pop_ready;

    // accept and integer accumulate
    q4q8_front #(
        .LANES   (LANES),
        .TDATA_W (S_TDATA_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .op_valid (push_valid),
        .op_ready (push_ready),
        .op_data  (push_data)
    );

    // request queue
    q4q8_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_data  (push_data),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_data  (pop_data)
    );

    // float back end
    q4q8_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op_valid (pop_valid),
        .op_ready (pop_ready),
        .op_data  (pop_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

// File: sv/q4q8_checker.sv
// ----------------------------------------------------------------------------
// q4q8_checker
// Port-level checks of the dot accumulator, bound to the top level.
// ----------------------------------------------------------------------------
`include "q4_q8_block_dot_accumulator_unit_defines.svh"

module q4q8_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // stalled result holds
    `Q4Q8_ASSERT_NXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // any NaN leaves in canonical form
    `Q4Q8_ASSERT_IMP(a_nan_canon, aclk, aresetn, m_tvalid && (m_tdata[30:23] == 8'hFF) && (m_tdata[22:0] != 23'd0), m_tdata == 32'h7FC0_0000)

    // after reset no result pending and the queue takes requests
    `Q4Q8_ASSERT_NXT(a_reset_clear, aclk, 1'b1, !aresetn, !m_tvalid && s_tready)

endmodule

bind q4_q8_block_dot_accumulator_unit q4q8_checker u_q4q8_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the q4 x q8 block dot accumulator: a streaming
// driver and a result monitor, with an fp32 fused multiply-add predictor.
// ----------------------------------------------------------------------------
module tb;
    import q4q8_pkg::*;

    localparam int TDATA_W = 160;
    localparam int CYCLE_LIMIT = 1500000;

    typedef struct {
        logic [31:0] nibbles;
        logic [63:0] acts;
        logic [12:0] act_sum;
        logic [15:0] w_half;
        logic [31:0] a_scale;
        logic        blk_end;
        logic        row_end;
    } chunk_t;

    logic                aclk;
    logic                aresetn;
    logic [TDATA_W-1:0]  s_tdata;
    logic                s_tuser;
    logic                s_tlast;
    logic                s_tvalid;
    logic                s_tready;
    logic [31:0]         m_tdata;
    logic                m_tvalid;
    logic                m_tready;

    chunk_t      chunk_queue[$];
    logic [31:0] row_totals[$];
    chunk_t      cur_chunk;

    // predictor state
    logic [19:0] blk_sum;
    logic [31:0] fp_total;

    int  mismatches;
    int  cycles;
    int  src_idle;
    int  snk_idle;
    bit  feeding_done;

    q4_q8_block_dot_accumulator_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // fp32 bits to double, exact
    function automatic real sp_to_real(logic [31:0] b);
        logic [63:0] d;
        logic [23:0] m;
        int          e;
        d = {b[31], 63'd0};
        m = {1'b0, b[22:0]};
        if (b[30:23] == 8'hFF) begin
            d[62:52] = 11'h7FF;
            d[51:0]  = {b[22:0], 29'd0};
        end else if (b[30:23] == 8'h00) begin
            if (m != 0) begin
                e = -126;
                while (!m[23]) begin
                    m = m << 1;
                    e--;
                end
                d[62:52] = 11'(e + 1023);
                d[51:0]  = {m[22:0], 29'd0};
            end
        end else begin
            d[62:52] = 11'(int'(b[30:23]) - 127 + 1023);
            d[51:0]  = {b[22:0], 29'd0};
        end
        return $bitstoreal(d);
    endfunction

    // double to fp32 bits, round to nearest even; NaN comes out canonical
    function automatic logic [31:0] real_to_sp(real r);
        logic [63:0] d;
        logic [63:0] sig;
        logic [63:0] kept;
        logic [63:0] rem;
        logic [63:0] half;
        int          e;
        int          sh;
        d = $realtobits(r);
        if (d[62:52] == 11'h7FF)
            return (d[51:0] != 0) ? CANON_NAN : {d[63], 8'hFF, 23'd0};
        if (d[62:52] == 0)
            return {d[63], 31'd0};
        e   = int'(d[62:52]) - 1023;
        sig = {11'd0, 1'b1, d[51:0]};
        if (e > 127)
            return {d[63], 8'hFF, 23'd0};
        sh = (e >= -126) ? 29 : 29 + (-126 - e);
        if (sh > 60)
            return {d[63], 31'd0};
        kept = sig >> sh;
        rem  = sig & ((64'd1 << sh) - 1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && kept[0]))
            kept = kept + 1;
        if (e >= -126) begin
            if (kept[24]) begin
                kept = kept >> 1;
                e++;
            end
            if (e > 127)
                return {d[63], 8'hFF, 23'd0};
            return {d[63], 8'(e + 127), kept[22:0]};
        end
        // subnormal; a carry into bit 23 lands in the exponent field
        return {d[63], kept[30:0]};
    endfunction

    function automatic logic [31:0] half_to_sp(logic [15:0] h);
        logic [10:0] m;
        int          e;
        m = {1'b0, h[9:0]};
        if (h[14:10] == 0) begin
            if (m == 0)
                return {h[15], 31'd0};
            e = 113;
            while (!m[10]) begin
                m = m << 1;
                e--;
            end
            return {h[15], 8'(e), m[9:0], 13'd0};
        end
        if (h[14:10] == 5'h1F)
            return {h[15], 8'hFF, h[9:0], 13'd0} | ((h[9:0] != 0) ? 32'h0040_0000 : 32'd0);
        return {h[15], 8'(int'(h[14:10]) + 112), h[9:0], 13'd0};
    endfunction

    // a*b + c rounded once: exact product, two-sum, round to odd, then to fp32
    function automatic logic [31:0] fused_madd_sp(logic [31:0] a, logic [31:0] b,
                                                  logic [31:0] c);
        real         p;
        real         cd;
        real         s;
        real         bb;
        real         err;
        logic [63:0] sb;
        p   = sp_to_real(a) * sp_to_real(b);
        cd  = sp_to_real(c);
        s   = p + cd;
        bb  = s - p;
        err = (p - (s - bb)) + (cd - bb);
        sb  = $realtobits(s);
        if (sb[62:52] != 11'h7FF && err == err && err != 0.0 && !sb[0]) begin
            if (sb[63] == (err < 0.0))
                sb = sb + 1;
            else
                sb = sb - 1;
            s = $bitstoreal(sb);
        end
        return real_to_sp(s);
    endfunction

    // advance the predicted row state by one accepted chunk
    task automatic accumulate_chunk(chunk_t c);
        logic [19:0] acc;
        logic [19:0] v;
        logic [31:0] scale;
        int          iv;
        acc = blk_sum;
        for (int j = 0; j < 8; j++)
            acc = acc + 20'(int'(c.nibbles[4*j +: 4] ^ NIB_FLIP)
                            * int'($signed(c.acts[8*j +: 8])));
        blk_sum = acc;
        if (c.blk_end) begin
            v     = blk_sum - 20'(8 * int'($signed(c.act_sum)));
            iv    = int'($signed(v));
            scale = real_to_sp(sp_to_real(half_to_sp(c.w_half)) * sp_to_real(c.a_scale));
            fp_total = fused_madd_sp(real_to_sp(real'(iv)), scale, fp_total);
            blk_sum  = '0;
        end
        if (c.row_end) begin
            row_totals.push_back(fp_total);
            fp_total = '0;
        end
    endtask

    function automatic chunk_t rand_chunk(bit blk_end, bit row_end);
        chunk_t c;
        c.nibbles = $urandom;
        c.acts    = {$urandom, $urandom};
        c.act_sum = 13'($urandom_range(8160) - 4096);
        if ($urandom_range(9) == 0) begin
            c.w_half  = 16'($urandom);
            c.a_scale = $urandom;
        end else begin
            c.w_half  = {1'($urandom), 5'($urandom_range(20, 5)), 10'($urandom)};
            c.a_scale = {1'($urandom), 8'($urandom_range(130, 100)), 23'($urandom)};
        end
        c.blk_end = blk_end;
        c.row_end = row_end;
        return c;
    endfunction

    function automatic chunk_t fixed_chunk(logic [31:0] n, logic [63:0] a, logic [12:0] s,
                                           logic [15:0] h, logic [31:0] f, bit be, bit re);
        chunk_t c;
        c.nibbles = n;
        c.acts    = a;
        c.act_sum = s;
        c.w_half  = h;
        c.a_scale = f;
        c.blk_end = be;
        c.row_end = re;
        return c;
    endfunction

    // request driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_idle <= 0;
        end else begin
            if (s_tvalid && s_tready)
                accumulate_chunk(cur_chunk);
            if (!s_tvalid || s_tready) begin
                if (src_idle > 0) begin
                    src_idle <= src_idle - 1;
                    s_tvalid <= 1'b0;
                end else if (chunk_queue.size() > 0) begin
                    cur_chunk = chunk_queue.pop_front();
                    s_tdata  <= {3'd0, cur_chunk.a_scale, cur_chunk.w_half, cur_chunk.act_sum,
                                 cur_chunk.acts, cur_chunk.nibbles};
                    s_tuser  <= cur_chunk.blk_end;
                    s_tlast  <= cur_chunk.row_end;
                    s_tvalid <= 1'b1;
                    if (chunk_queue.size() > 200 && $urandom_range(7) == 0)
                        src_idle <= $urandom_range(5, 1);
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            snk_idle <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (row_totals.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h", m_tdata);
                end else begin
                    logic [31:0] want;
                    want = row_totals.pop_front();
                    if (m_tdata !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("dot_result_bits mismatch: expected %h actual %h",
                                     want, m_tdata);
                    end
                end
            end
            if (snk_idle > 0) begin
                snk_idle <= snk_idle - 1;
                m_tready <= 1'b0;
            end else if (!feeding_done && $urandom_range(5) == 0) begin
                snk_idle <= $urandom_range(4);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int nblk;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = 1'b0;
        s_tlast      = 1'b0;
        m_tready     = 1'b0;
        aresetn      = 1'b0;
        cycles       = 0;
        mismatches   = 0;
        feeding_done = 1'b0;
        src_idle     = 0;
        snk_idle     = 0;
        blk_sum      = '0;
        fp_total     = '0;

        // corner cases: nibble and activation extremes, sum extremes
        chunk_queue.push_back(fixed_chunk(32'h0, {8{8'h80}}, 13'h1000, 16'h3C00,
                                          32'h3F80_0000, 0, 0));
        chunk_queue.push_back(fixed_chunk(32'hFFFF_FFFF, {8{8'h7F}}, 13'h0FE0, 16'h3C00,
                                          32'h3F80_0000, 0, 0));
        chunk_queue.push_back(fixed_chunk(32'h0, {8{8'h80}}, 13'h0, 16'h3C00,
                                          32'h3F80_0000, 0, 0));
        chunk_queue.push_back(fixed_chunk(32'h7777_7777, {8{8'h7F}}, 13'h1000, 16'h3C00,
                                          32'h3F80_0000, 1, 1));
        // block closing after one chunk, and a row end with no block close
        chunk_queue.push_back(fixed_chunk(32'h1234_5678, 64'h0102_0304_FEFD_FCFB, 13'h0FE0,
                                          16'h0001, 32'h0000_0001, 1, 0));
        chunk_queue.push_back(fixed_chunk(32'h8888_8888, {8{8'hFF}}, 13'h0, 16'h0,
                                          32'h0, 0, 1));
        chunk_queue.push_back(fixed_chunk(32'hFFFF_FFFF, {8{8'h80}}, 13'h1000, 16'h0001,
                                          32'h0080_0000, 1, 1));
        // fp16 specials: infinity, NaN, subnormal; zero times infinity
        chunk_queue.push_back(fixed_chunk(32'h0, {8{8'h01}}, 13'h0, 16'h7C00,
                                          32'h3F80_0000, 1, 1));
        chunk_queue.push_back(fixed_chunk(32'h0, {8{8'h01}}, 13'h0, 16'hFE00,
                                          32'h3F80_0000, 1, 1));
        chunk_queue.push_back(fixed_chunk(32'h0, {8{8'h01}}, 13'h0, 16'h7C00,
                                          32'h0, 1, 1));
        chunk_queue.push_back(fixed_chunk(32'hFFFF_FFFF, {8{8'h7F}}, 13'h0, 16'h83FF,
                                          32'h7F80_0001, 1, 1));
        // overflow to infinity, then a row of two blocks with subnormal scales
        chunk_queue.push_back(fixed_chunk(32'hFFFF_FFFF, {8{8'h7F}}, 13'h1000, 16'h7BFF,
                                          32'h7F7F_FFFF, 1, 1));
        chunk_queue.push_back(fixed_chunk(32'h9999_9999, {8{8'h01}}, 13'h0, 16'h0400,
                                          32'h0080_0000, 1, 0));
        chunk_queue.push_back(fixed_chunk(32'h7777_7777, {8{8'h01}}, 13'h0, 16'h0400,
                                          32'h0080_0000, 1, 1));
        chunk_queue.push_back(fixed_chunk(32'h0, 64'h0, 13'h0, 16'h0, 32'h0, 0, 1));

        // well-formed rows of full blocks, with some broken framing mixed in
        while (chunk_queue.size() < 1715) begin
            nblk = $urandom_range(4, 1);
            for (int b = 0; b < nblk; b++) begin
                int nchk;
                nchk = ($urandom_range(7) == 0) ? $urandom_range(6, 1) : 4;
                for (int k = 0; k < nchk; k++)
                    chunk_queue.push_back(rand_chunk(k == nchk - 1,
                                          (b == nblk - 1 && k == nchk - 1)));
            end
            if ($urandom_range(9) == 0)
                chunk_queue.push_back(rand_chunk(0, 1));
        end
        chunk_queue.push_back(rand_chunk(1, 1));

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        wait (chunk_queue.size() == 0);
        feeding_done = 1'b1;
        @(posedge aclk);
        while (s_tvalid || row_totals.size() != 0)
            @(posedge aclk);
        repeat (100) @(posedge aclk);
        if (mismatches == 0 && row_totals.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: q4_q8_block_dot_accumulator_unit.f
+incdir+sv
sv/q4q8_pkg.sv
sv/q4q8_fifo.sv
sv/q4q8_front.sv
sv/q4q8_back.sv
sv/q4_q8_block_dot_accumulator_unit.sv
sv/q4q8_checker.sv
tb/tb.sv
